@@ sv/soke_pkg.sv @@
// ----------------------------------------------------------------------------
// soke_pkg: shared types and constants for the spiral-order lookup block
// Field widths, register indexes, input kinds and the walker status struct.
// ----------------------------------------------------------------------------
package soke_pkg;

    localparam int MAX_DIM_DEF    = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int ROW_W   = 6;
    localparam int COL_W   = 6;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 13;
    localparam int ELEM_W  = 32;
    localparam int CFG_W   = 7;

    // configuration register indexes
    localparam logic CFG_NUM_ROWS = 1'b0;
    localparam logic CFG_NUM_COLS = 1'b1;

    // input item kinds (tuser)
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic done;
        logic oor;
    } t_walk_stat;

endpackage

@@ sv/soke_walker.sv @@
// ----------------------------------------------------------------------------
// soke_walker: spiral position to matrix address
// Range-checks k, then peels one ring perimeter per cycle through a shared
// compare/subtract unit, then resolves the side of the ring into an address.
// ----------------------------------------------------------------------------
module soke_walker #(
    parameter int MAX_DIM = soke_pkg::MAX_DIM_DEF,
    parameter int DW      = $clog2(MAX_DIM + 1),
    parameter int IDXW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [soke_pkg::POS_W-1:0] i_k,
    input  logic [DW-1:0]            i_rows,
    input  logic [DW-1:0]            i_cols,
    output soke_pkg::t_walk_stat     o_stat,
    output logic [2*IDXW-1:0]        o_addr
);

    localparam int PW  = $clog2(4 * MAX_DIM);
    localparam int CW  = (PW > soke_pkg::POS_W) ? PW : soke_pkg::POS_W;
    localparam int MW0 = 2 * DW;
    localparam int MW  = (MW0 > soke_pkg::POS_W) ? MW0 : soke_pkg::POS_W;

    typedef enum logic [3:0] {
        W_IDLE   = 4'b0001,
        W_CHECK  = 4'b0010,
        W_RING   = 4'b0100,
        W_LOCATE = 4'b1000
    } t_wstate;

    t_wstate                r_state, n_state;
    logic [CW-1:0]          r_p, n_p;
    logic [DW-1:0]          r_t, n_t;
    logic [DW-1:0]          r_h, n_h;
    logic [DW-1:0]          r_w, n_w;
    logic [2*IDXW-1:0]      r_addr, n_addr;
    soke_pkg::t_walk_stat   r_stat, n_stat;

    logic [MW0-1:0] area;
    logic           oor;
    logic [CW-1:0]  h_e, w_e, t_e, perim;
    logic [CW-1:0]  row_c, col_c;

    assign area  = MW0'(i_rows) * MW0'(i_cols);
    assign oor   = (r_p == '0) || (MW'(r_p) > MW'(area));

    assign h_e   = CW'(r_h);
    assign w_e   = CW'(r_w);
    assign t_e   = CW'(r_t);

    // ring perimeter, collapsed rings counted once per cell
    always_comb begin
        priority if (r_h == DW'(1)) begin
            perim = w_e;
        end else if (r_w == DW'(1)) begin
            perim = h_e;
        end else begin
            perim = ((h_e + w_e) << 1) - CW'(4);
        end
    end

    // side of the ring: top, right, bottom, left
    always_comb begin
        priority if (r_p < w_e) begin
            row_c = t_e;
            col_c = t_e + r_p;
        end else if (r_p < w_e + h_e - CW'(1)) begin
            row_c = t_e + CW'(1) + (r_p - w_e);
            col_c = t_e + w_e - CW'(1);
        end else if (r_p < (w_e << 1) + h_e - CW'(2)) begin
            row_c = t_e + h_e - CW'(1);
            col_c = t_e + (w_e << 1) + h_e - CW'(3) - r_p;
        end else begin
            row_c = t_e + (h_e << 1) + (w_e << 1) - CW'(4) - r_p;
            col_c = t_e;
        end
    end

    always_comb begin
        n_state = r_state;
        n_p     = r_p;
        n_t     = r_t;
        n_h     = r_h;
        n_w     = r_w;
        n_addr  = r_addr;
        n_stat  = '0;
        unique case (r_state)
            W_IDLE: begin
                if (i_start) begin
                    n_p     = CW'(i_k);
                    n_state = W_CHECK;
                end
            end
            W_CHECK: begin
                if (oor) begin
                    n_stat.done = 1'b1;
                    n_stat.oor  = 1'b1;
                    n_state     = W_IDLE;
                end else begin
                    n_p     = r_p - CW'(1);
                    n_t     = '0;
                    n_h     = i_rows;
                    n_w     = i_cols;
                    n_state = W_RING;
                end
            end
            W_RING: begin
                if (r_p < perim) begin
                    n_state = W_LOCATE;
                end else begin
                    n_p = r_p - perim;
                    n_t = r_t + DW'(1);
                    n_h = r_h - DW'(2);
                    n_w = r_w - DW'(2);
                end
            end
            W_LOCATE: begin
                n_addr      = {IDXW'(row_c), IDXW'(col_c)};
                n_stat.done = 1'b1;
                n_state     = W_IDLE;
            end
            default: n_state = W_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
            r_stat  <= '0;
        end else begin
            r_state <= n_state;
            r_stat  <= n_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p    <= n_p;
        r_t    <= n_t;
        r_h    <= n_h;
        r_w    <= n_w;
        r_addr <= n_addr;
    end

    assign o_stat = r_stat;
    assign o_addr = r_addr;

endmodule

@@ sv/spiral_order_kth_element.sv @@
// Write beat: accepted with no result; writes can follow back to back.
// Query beat: the next beat is taken only once the result is registered at the output;
// the walker peels rings before the hit (0 to MAX_DIM/2 - 1), one per cycle in the shared
// perimeter subtract; an out-of-range k skips the ring walk and the store read.
// A result still waiting at the output holds the next query in its last stage.
// Synchronous active-low reset clears control, sets both dimensions to 1; store kept.
// ----------------------------------------------------------------------------
// spiral_order_kth_element: k-th element of a stored matrix in spiral order
// Stores elements by row/column and answers one-based spiral position queries.
// ----------------------------------------------------------------------------
module spiral_order_kth_element #(
    parameter int MAX_DIM    = soke_pkg::MAX_DIM_DEF,
    parameter int DATA_WIDTH = soke_pkg::DATA_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config write port
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_addr,
    input  logic [soke_pkg::CFG_W-1:0]  i_cfg_wdata,
    // input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [63:0]                 s_axis_tdata,  // row, col, value, position
    input  logic                        s_axis_tuser,  // func
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata,  // element
    output logic                        m_axis_tuser   // out_of_range
);

    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int IDXW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH = 1 << (2 * IDXW);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_READ = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    logic [DW-1:0]                   r_rows, r_cols;
    logic                            r_oor;
    logic [DATA_WIDTH-1:0]           r_rd_data;
    logic                            r_m_valid;
    logic [soke_pkg::ELEM_W-1:0]     r_m_elem;
    logic                            r_m_oor;
    logic [DATA_WIDTH-1:0]           r_mem [0:DEPTH-1];

    logic [soke_pkg::ROW_W-1:0]      in_row;
    logic [soke_pkg::COL_W-1:0]      in_col;
    logic [soke_pkg::VALUE_W-1:0]    in_value;
    logic [soke_pkg::POS_W-1:0]      in_pos;
    logic                            accept, wr_en, start, out_free;
    logic [DW-1:0]                   cfg_dim;
    soke_pkg::t_walk_stat            walk_stat;
    logic [2*IDXW-1:0]               walk_addr;

    assign in_row   = s_axis_tdata[5:0];
    assign in_col   = s_axis_tdata[11:6];
    assign in_value = s_axis_tdata[43:12];
    assign in_pos   = s_axis_tdata[56:44];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign wr_en = accept && (s_axis_tuser == soke_pkg::FUNC_WRITE)
                   && (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
    assign start = accept && (s_axis_tuser == soke_pkg::FUNC_QUERY);
    assign out_free = !r_m_valid || m_axis_tready;

    // dimension clamp: zero reads as 1, oversize as MAX_DIM
    always_comb begin
        priority if (i_cfg_wdata == '0) begin
            cfg_dim = DW'(1);
        end else if (32'(i_cfg_wdata) > MAX_DIM) begin
            cfg_dim = DW'(MAX_DIM);
        end else begin
            cfg_dim = DW'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= DW'(1);
            r_cols <= DW'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                soke_pkg::CFG_NUM_ROWS: r_rows <= cfg_dim;
                soke_pkg::CFG_NUM_COLS: r_cols <= cfg_dim;
                default: ;
            endcase
        end
    end

    soke_walker #(
        .MAX_DIM (MAX_DIM),
        .DW      (DW),
        .IDXW    (IDXW)
    ) u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_k     (in_pos),
        .i_rows  (r_rows),
        .i_cols  (r_cols),
        .o_stat  (walk_stat),
        .o_addr  (walk_addr)
    );

    // element store, addressed {row, col}
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[{IDXW'(in_row), IDXW'(in_col)}] <= DATA_WIDTH'(in_value);
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_mem[walk_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start) n_state = S_WALK;
            S_WALK: begin
                if (walk_stat.done) begin
                    n_state = walk_stat.oor ? S_OUT : S_READ;
                end
            end
            S_READ: n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WALK && walk_stat.done) begin
            r_oor <= walk_stat.oor;
        end
        if (r_state == S_OUT && out_free) begin
            r_m_elem <= r_oor ? '0 : soke_pkg::ELEM_W'(r_rd_data);
            r_m_oor  <= r_oor;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_elem;
    assign m_axis_tuser  = r_m_oor;

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: spiral-order lookup block
// Writes random matrix elements, sweeps matrix sizes through config writes and
// checks every spiral position lookup against a predictor built into a small
// scoreboard class. Both stream sides run with random gaps and stalls outside calm phases.
// ----------------------------------------------------------------------------

// tdata layout of an input beat, highest bits first
typedef struct packed {
    logic [6:0]                   pad;
    logic [soke_pkg::POS_W-1:0]   position;
    logic [soke_pkg::VALUE_W-1:0] value;
    logic [soke_pkg::COL_W-1:0]   col;
    logic [soke_pkg::ROW_W-1:0]   row;
} t_item_bits;

typedef struct packed {
    logic [soke_pkg::ELEM_W-1:0] element;
    logic                        out_of_range;
} t_lookup;

class spiral_checker;
    logic [soke_pkg::ELEM_W-1:0] cells [0:4095];
    int                          rows;
    int                          cols;
    int                          errors;
    t_lookup                     pending_lookups [$];

    function new();
        rows   = 1;
        cols   = 1;
        errors = 0;
    endfunction

    function void set_dim(logic idx, logic [soke_pkg::CFG_W-1:0] v);
        int d;
        d = (v == 0) ? 1 : ((v > 64) ? 64 : int'(v));
        if (idx == soke_pkg::CFG_NUM_ROWS) rows = d;
        else cols = d;
    endfunction

    // zero-based spiral position -> cell, for the size in use
    function void spiral_cell(int p, output int r, output int c);
        int t, l, b, rt, h, w, ring;
        t = 0;
        l = 0;
        b = rows - 1;
        rt = cols - 1;
        r = 0;
        c = 0;
        while (t <= b && l <= rt) begin
            h = b - t + 1;
            w = rt - l + 1;
            if (h == 1) ring = w;
            else if (w == 1) ring = h;
            else ring = 2 * (h + w) - 4;
            if (p < ring) begin
                if (p < w) begin
                    r = t;
                    c = l + p;
                end else if (p < w + h - 1) begin
                    r = t + 1 + (p - w);
                    c = rt;
                end else if (p < 2 * w + h - 2) begin
                    r = b;
                    c = rt - 1 - (p - w - h + 1);
                end else begin
                    r = b - 1 - (p - 2 * w - h + 2);
                    c = l;
                end
                return;
            end
            p -= ring;
            t++;
            l++;
            b--;
            rt--;
        end
    endfunction

    function void note_beat(logic func, logic [63:0] data);
        t_item_bits b;
        t_lookup    res;
        int         r, c;
        b = data;
        if (func == soke_pkg::FUNC_WRITE) begin
            cells[{b.row, b.col}] = b.value;
            return;
        end
        if (b.position == 0 || int'(b.position) > rows * cols) begin
            res.element      = '0;
            res.out_of_range = 1'b1;
        end else begin
            spiral_cell(int'(b.position) - 1, r, c);
            res.element      = cells[r * 64 + c];
            res.out_of_range = 1'b0;
        end
        pending_lookups.push_back(res);
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_lookup(logic [31:0] element, logic oor);
        t_lookup exp_res;
        if (pending_lookups.size() == 0) begin
            report($sformatf("unexpected result element=%h oor=%b", element, oor));
            return;
        end
        exp_res = pending_lookups.pop_front();
        if (element !== exp_res.element)
            report($sformatf("element %h, want %h", element, exp_res.element));
        if (oor !== exp_res.out_of_range)
            report($sformatf("out_of_range %b, want %b", oor, exp_res.out_of_range));
    endtask
endclass

module testbench;
    import soke_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 8;
    localparam int PHASE_ITEMS = 60;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic                i_cfg_addr    = CFG_NUM_ROWS;
    logic [CFG_W-1:0]    i_cfg_wdata   = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [63:0]         s_axis_tdata  = '0;  // row, col, value, position
    logic                s_axis_tuser  = FUNC_WRITE;  // func
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [31:0]         m_axis_tdata;  // element
    logic                m_axis_tuser;  // out_of_range

    spiral_checker sb;
    bit            cell_written [0:63][0:63];
    bit            calm;
    int            items_sent;

    spiral_order_kth_element i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, a few long ones
    function int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50) return 0;
        if (sel < 85) return $urandom_range(1, 3);
        if (sel < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_beat(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_lookup(m_axis_tdata, m_axis_tuser);
        end
    end

    // result side back-pressure
    initial begin
        int stall_left;
        int gap;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (calm) begin
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                gap = pick_gap();
                m_axis_tready <= (gap == 0);
                stall_left = (gap > 0) ? gap - 1 : 0;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    task send_item(logic func, logic [5:0] row, logic [5:0] col, logic [31:0] value,
                   logic [12:0] pos);
        t_item_bits b;
        int         gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        b.pad      = '0;
        b.position = pos;
        b.value    = value;
        b.col      = col;
        b.row      = row;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task send_write(int r, int c, logic [31:0] value);
        cell_written[r][c] = 1'b1;
        send_item(FUNC_WRITE, r[5:0], c[5:0], value, 13'($urandom));
    endtask

    // a lookup that would land on a never-written cell gets that cell written first
    task send_query(int k);
        int r, c;
        if (k >= 1 && k <= sb.rows * sb.cols) begin
            sb.spiral_cell(k - 1, r, c);
            if (!cell_written[r][c]) send_write(r, c, pick_value());
        end
        send_item(FUNC_QUERY, 6'($urandom), 6'($urandom), $urandom, k[12:0]);
    endtask

    task wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_lookups.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task config_dims(logic [CFG_W-1:0] rows_v, logic [CFG_W-1:0] cols_v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_NUM_ROWS;
        i_cfg_wdata <= rows_v;
        @(posedge i_clk);
        sb.set_dim(CFG_NUM_ROWS, rows_v);
        i_cfg_addr  <= CFG_NUM_COLS;
        i_cfg_wdata <= cols_v;
        @(posedge i_clk);
        sb.set_dim(CFG_NUM_COLS, cols_v);
        i_cfg_we    <= 1'b0;
    endtask

    task random_item();
        int area;
        int sel;
        area = sb.rows * sb.cols;
        sel  = $urandom_range(0, 99);
        if (sel < 30)
            send_write($urandom_range(0, 63), $urandom_range(0, 63), pick_value());
        else if (sel < 40)
            send_write($urandom_range(0, sb.rows - 1), $urandom_range(0, sb.cols - 1),
                       pick_value());
        else if (sel < 80)
            send_query($urandom_range(1, area));
        else if (sel < 85)
            send_query(0);
        else if (sel < 90)
            send_query(area);
        else if (sel < 95)
            send_query($urandom_range(area + 1, 8191));
        else
            send_query($urandom_range(0, 8191));
    endtask

    initial begin
        int rows_list [12] = '{1, 1, 64, 64, 2, 3, 5, 7, 2, 10, 4, 6};
        int cols_list [12] = '{1, 64, 1, 64, 2, 5, 3, 7, 9, 4, 11, 6};
        int start;
        bit pause_done;
        sb         = new();
        calm       = 1'b0;
        items_sent = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: size 1x1 straight out of reset
        send_query(0);
        send_write(0, 0, 32'h8000_0000);
        send_query(1);
        send_query(2);
        send_query(8191);
        send_write(63, 63, 32'h7FFF_FFFF);  // stored though outside the size in use
        // zero clamps to one, oversize clamps to the maximum: single row
        config_dims(7'd0, 7'd127);
        send_query(64);
        send_query(65);
        send_query(33);
        // single column
        config_dims(7'd100, 7'd0);
        send_query(64);
        send_query(1);
        config_dims(7'd64, 7'd64);
        send_query(4096);
        send_query(4097);
        // centre cell, trailing single row, trailing single column
        config_dims(7'd3, 7'd3);
        send_query(9);
        config_dims(7'd3, 7'd5);
        send_query(15);
        config_dims(7'd5, 7'd3);
        send_query(15);

        pause_done = 1'b0;
        for (int p = 0; p < 15; p++) begin
            if (p < 12)
                config_dims(rows_list[p][6:0], cols_list[p][6:0]);
            else
                config_dims(7'($urandom_range(0, 16)), 7'($urandom_range(0, 16)));
            calm  = ($urandom_range(0, 3) == 0);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                random_item();
                if (items_sent - start >= PHASE_ITEMS / 2 && !pause_done) begin
                    pause_done = ($urandom_range(0, 1) == 0) || (p == 0);
                    if (pause_done) wait_idle();
                end
            end
            pause_done = 1'b0;
        end

        calm = 1'b0;
        wait_idle();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
